[sv/tps_pkg.sv]
// Shared types and constants of the transport stream PES packetizer.
// No dependencies; every other file of the block imports this package.
package tps_pkg;

  localparam int STREAM_SLOTS_DEF = 16;
  localparam int PKT_LEN          = 188;
  localparam int ROOM             = 184;
  localparam int POS_W            = 8;
  localparam int LAST_POS         = PKT_LEN - 1;

  localparam logic [7:0] SYNC_BYTE  = 8'h47;
  localparam logic [7:0] PUSI_BIT   = 8'h40;
  localparam logic [7:0] AFC_PAY    = 8'h10;
  localparam logic [7:0] AFC_AF     = 8'h20;
  localparam logic [7:0] AFC_BOTH   = 8'h30;
  localparam logic [7:0] STUFF_BYTE = 8'hFF;
  localparam logic [7:0] DISC_FLAG  = 8'h80;
  localparam logic [7:0] RA_FLAG    = 8'h40;
  localparam logic [7:0] PCR_FLAG   = 8'h10;
  localparam logic [6:0] PCR_RSVD   = 7'h7E;

  // 27000 ticks per ms against 300 per DTS tick leaves 90 DTS ticks per ms.
  localparam logic [6:0] DTS_TICKS_PER_MS = 7'd90;

  localparam int AF_DISC = 2;
  localparam int AF_RA   = 1;
  localparam int AF_PCR  = 0;

  localparam logic CFG_PCR_PID      = 1'b0;
  localparam logic CFG_PCR_INTERVAL = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PROC,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic       disc_we;
    logic       disc_val;
    logic       cc_we;
    logic [3:0] cc_val;
  } slot_wr_t;

  typedef struct packed {
    logic       disc;
    logic [3:0] cc;
  } slot_rd_t;

endpackage

[sv/tps_slot_mem.sv]
// Per-stream record memory: continuity counter and pending discontinuity mark.
// Depends on tps_pkg. Entries never written read as zero via valid bits.
module tps_slot_mem #(
  parameter int STREAM_SLOTS = tps_pkg::STREAM_SLOTS_DEF,
  parameter int SW           = 4
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [SW-1:0]     rd_addr,
  output tps_pkg::slot_rd_t rd_data,
  input  logic [SW-1:0]     disc_waddr,
  input  logic [SW-1:0]     cc_waddr,
  input  tps_pkg::slot_wr_t wr
);
  import tps_pkg::*;

  logic [3:0]              cc_mem   [STREAM_SLOTS];
  logic                    disc_mem [STREAM_SLOTS];
  logic [STREAM_SLOTS-1:0] cc_vld_r;
  logic [STREAM_SLOTS-1:0] disc_vld_r;
  logic [3:0]              cc_q_r;
  logic                    disc_q_r;
  logic                    cc_qv_r;
  logic                    disc_qv_r;

  always_ff @(posedge clk) begin
    if (wr.cc_we) begin
      cc_mem[cc_waddr] <= wr.cc_val;
    end
    if (wr.disc_we) begin
      disc_mem[disc_waddr] <= wr.disc_val;
    end
    cc_q_r   <= cc_mem[rd_addr];
    disc_q_r <= disc_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cc_vld_r   <= '0;
      disc_vld_r <= '0;
      cc_qv_r    <= 1'b0;
      disc_qv_r  <= 1'b0;
    end else begin
      if (wr.cc_we) begin
        cc_vld_r[cc_waddr] <= 1'b1;
      end
      if (wr.disc_we) begin
        disc_vld_r[disc_waddr] <= 1'b1;
      end
      cc_qv_r   <= cc_vld_r[rd_addr];
      disc_qv_r <= disc_vld_r[rd_addr];
    end
  end

  assign rd_data.cc   = cc_qv_r ? cc_q_r : 4'd0;
  assign rd_data.disc = disc_qv_r & disc_q_r;

endmodule

[sv/tps_pay_mem.sv]
// Payload byte store of the packet being built, one write and one read port.
// Depends on tps_pkg for the payload room size.
module tps_pay_mem (
  input  logic       clk,
  input  logic       we,
  input  logic [7:0] waddr,
  input  logic [7:0] wdata,
  input  logic [7:0] raddr,
  output logic [7:0] rdata
);
  import tps_pkg::*;

  logic [7:0] mem [ROOM];
  logic [7:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

[sv/ts_pes_packetizer_core.sv]
// Transport stream PES packetizer top level: control sequencer and word builder.
// Depends on tps_pkg, tps_slot_mem and tps_pay_mem.
//
// A data byte is accepted in the idle state; the processing state then takes
// its slot record read and writes the payload byte. A closing byte is followed
// by packet emission: each of the 188 packet bytes passes through the payload
// memory read port in an address and a capture phase, output stall holds it,
// and the packet leaves as 24 beats of 8 bytes, the last carrying 4. A
// discontinuity mark request is written on acceptance. The result register lets
// the next item in while the last beat of a packet still waits.
module ts_pes_packetizer_core #(
  parameter int STREAM_SLOTS = tps_pkg::STREAM_SLOTS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // [3:0] stream_slot, [16:4] pid, [24:17] data_byte, [25] au_first,
  // [26] keyframe, [59:27] dts_90k, [63:60] zero
  input  logic [63:0] in_tdata,
  input  logic        in_tlast,   // au_last
  input  logic        in_tuser,   // func
  output logic        out_tvalid,
  input  logic        out_tready,
  // [63:0] out_word, [67:64] out_count, [71:68] zero
  output logic [71:0] out_tdata,
  output logic        out_tlast,  // packet_end
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_addr,
  input  logic [15:0] cfg_data
);
  import tps_pkg::*;

  localparam int SW = (STREAM_SLOTS > 1) ? $clog2(STREAM_SLOTS) : 1;

  state_t      state_r, state_nxt;
  logic [12:0] pcr_pid_r;
  logic [15:0] pcr_ms_r;

  logic [7:0]  byte_r;
  logic        first_r, last_r, key_r;
  logic [32:0] dts_in_r;
  logic [12:0] pid_in_r;
  logic [SW-1:0] slot_in_r;

  logic [7:0]  fill_r, fill_nxt;
  logic        open_r, open_nxt;
  logic [2:0]  flags_r, flags_nxt;
  logic [12:0] pid_r, pid_nxt;
  logic [SW-1:0] slot_r, slot_nxt;
  logic [32:0] dts_r, dts_nxt;
  logic        pcr_seen_r, pcr_seen_nxt;
  logic [32:0] last_pcr_r, last_pcr_nxt;
  logic [7:0]  af_total_r, af_total_nxt;
  logic [3:0]  cc_r, cc_nxt;

  logic [POS_W-1:0] pos_r, pos_nxt;
  logic        phase_r, phase_nxt;
  logic [63:0] bld_r, bld_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [63:0] out_word_r, out_word_nxt;
  logic [3:0]  out_cnt_r, out_cnt_nxt;
  logic        out_end_r, out_end_nxt;

  logic [SW-1:0] slot_in;
  logic [SW-1:0] rd_addr;
  slot_rd_t    slot_rd;
  slot_wr_t    slot_wr;
  logic [SW-1:0] disc_waddr;

  logic        pay_we;
  logic [7:0]  pay_waddr;
  logic [7:0]  pay_raddr;
  logic [7:0]  pay_rdata;

  logic        in_acc;
  logic [7:0]  fill_base, fill_new, af_size, cap;
  logic [2:0]  fl;
  logic [32:0] dts_diff;
  logic [22:0] pcr_limit;
  logic [7:0]  pkt_byte;
  logic [7:0]  af_len;
  logic [2:0]  hdr_fl;

  assign in_tready = (state_r == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign in_acc    = in_tvalid & in_tready;

  // Slot index reduced modulo the slot count through a constant table.
  always_comb begin
    slot_in = '0;
    for (int i = 0; i < 16; i++) begin
      if (in_tdata[3:0] == 4'(i)) begin
        slot_in = SW'(i % STREAM_SLOTS);
      end
    end
  end

  assign rd_addr    = (!in_tuser && !in_tdata[25]) ? slot_r : slot_in;
  assign disc_waddr = (state_r == ST_IDLE) ? slot_in : slot_in_r;

  tps_slot_mem #(.STREAM_SLOTS(STREAM_SLOTS), .SW(SW)) u_slot (
    .clk       (clk),
    .rst_n     (rst_n),
    .rd_addr   (rd_addr),
    .rd_data   (slot_rd),
    .disc_waddr(disc_waddr),
    .cc_waddr  (slot_nxt),
    .wr        (slot_wr)
  );

  tps_pay_mem u_pay (
    .clk  (clk),
    .we   (pay_we),
    .waddr(pay_waddr),
    .wdata(byte_r),
    .raddr(pay_raddr),
    .rdata(pay_rdata)
  );

  assign dts_diff  = dts_in_r - last_pcr_r;
  assign pcr_limit = 23'(pcr_ms_r * DTS_TICKS_PER_MS);

  // Packet byte at pos_r; the payload byte arrives from memory this cycle.
  always_comb begin
    af_len   = af_total_r - 8'd1;
    hdr_fl   = open_r ? flags_r : 3'd0;
    pkt_byte = STUFF_BYTE;
    if (pos_r == 8'd0) begin
      pkt_byte = SYNC_BYTE;
    end else if (pos_r == 8'd1) begin
      pkt_byte = (open_r ? PUSI_BIT : 8'h00) | {3'b000, pid_r[12:8]};
    end else if (pos_r == 8'd2) begin
      pkt_byte = pid_r[7:0];
    end else if (pos_r == 8'd3) begin
      pkt_byte = ((af_total_r == 8'd0) ? AFC_PAY :
                  ((fill_r == 8'd0) ? AFC_AF : AFC_BOTH)) | {4'h0, cc_r};
    end else if (pos_r >= 8'd4 + af_total_r) begin
      pkt_byte = pay_rdata;
    end else if (pos_r == 8'd4) begin
      pkt_byte = af_len;
    end else if (pos_r == 8'd5) begin
      pkt_byte = (hdr_fl[AF_DISC] ? DISC_FLAG : 8'h00) |
                 (hdr_fl[AF_RA] ? RA_FLAG : 8'h00) |
                 (hdr_fl[AF_PCR] ? PCR_FLAG : 8'h00);
    end else if (hdr_fl[AF_PCR] && pos_r <= 8'd11) begin
      case (pos_r)
        8'd6:    pkt_byte = dts_r[32:25];
        8'd7:    pkt_byte = dts_r[24:17];
        8'd8:    pkt_byte = dts_r[16:9];
        8'd9:    pkt_byte = dts_r[8:1];
        8'd10:   pkt_byte = {dts_r[0], PCR_RSVD};
        default: pkt_byte = 8'h00;
      endcase
    end
  end

  assign pay_raddr = pos_r - af_total_r - 8'd4;

  always_comb begin
    state_nxt     = state_r;
    fill_nxt      = fill_r;
    open_nxt      = open_r;
    flags_nxt     = flags_r;
    pid_nxt       = pid_r;
    slot_nxt      = slot_r;
    dts_nxt       = dts_r;
    pcr_seen_nxt  = pcr_seen_r;
    last_pcr_nxt  = last_pcr_r;
    af_total_nxt  = af_total_r;
    cc_nxt        = cc_r;
    pos_nxt       = pos_r;
    phase_nxt     = phase_r;
    bld_nxt       = bld_r;
    out_valid_nxt = out_valid_r & ~out_tready;
    out_word_nxt  = out_word_r;
    out_cnt_nxt   = out_cnt_r;
    out_end_nxt   = out_end_r;
    slot_wr       = '0;
    pay_we        = 1'b0;
    fill_base     = first_r ? 8'd0 : fill_r;
    pay_waddr     = fill_base;
    fill_new      = fill_base + 8'd1;
    fl            = flags_r;
    af_size       = 8'd0;
    cap           = 8'(ROOM);

    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_tuser) begin
            slot_wr.disc_we  = 1'b1;
            slot_wr.disc_val = 1'b1;
          end else begin
            state_nxt = ST_PROC;
          end
        end
      end
      ST_PROC: begin
        if (first_r) begin
          fl = {slot_rd.disc, key_r, 1'b0};
          slot_wr.disc_we  = 1'b1;
          slot_wr.disc_val = 1'b0;
          if (pid_in_r == pcr_pid_r &&
              (key_r || !pcr_seen_r || dts_diff >= 33'(pcr_limit))) begin
            fl[AF_PCR]   = 1'b1;
            pcr_seen_nxt = 1'b1;
            last_pcr_nxt = dts_in_r;
          end
          pid_nxt   = pid_in_r;
          slot_nxt  = slot_in_r;
          dts_nxt   = dts_in_r;
          flags_nxt = fl;
          open_nxt  = 1'b1;
        end
        if ((first_r || open_r) && fl != 3'd0) begin
          af_size = fl[AF_PCR] ? 8'd8 : 8'd2;
        end
        cap      = 8'(ROOM) - af_size;
        pay_we   = 1'b1;
        fill_nxt = fill_new;
        if (fill_new >= cap || last_r) begin
          af_total_nxt    = 8'(ROOM) - fill_new;
          cc_nxt          = slot_rd.cc;
          slot_wr.cc_we   = 1'b1;
          slot_wr.cc_val  = slot_rd.cc + 4'd1;
          pos_nxt         = '0;
          phase_nxt       = 1'b0;
          state_nxt       = ST_EMIT;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_EMIT: begin
        if (!phase_r) begin
          // A new beat starts only once the result register is free.
          if (pos_r[2:0] != 3'd0 || !out_valid_r) begin
            phase_nxt = 1'b1;
          end
        end else begin
          phase_nxt = 1'b0;
          bld_nxt   = {bld_r[55:0], pkt_byte};
          pos_nxt   = pos_r + 8'd1;
          if (pos_r == 8'(LAST_POS)) begin
            out_valid_nxt = 1'b1;
            out_word_nxt  = {bld_nxt[31:0], 32'h0};
            out_cnt_nxt   = 4'd4;
            out_end_nxt   = 1'b1;
            open_nxt      = 1'b0;
            fill_nxt      = 8'd0;
            pos_nxt       = '0;
            state_nxt     = ST_IDLE;
          end else if (pos_r[2:0] == 3'd7) begin
            out_valid_nxt = 1'b1;
            out_word_nxt  = bld_nxt;
            out_cnt_nxt   = 4'd8;
            out_end_nxt   = 1'b0;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      pcr_pid_r   <= 13'h1FFF;
      pcr_ms_r    <= 16'd40;
      fill_r      <= '0;
      open_r      <= 1'b0;
      flags_r     <= '0;
      pid_r       <= '0;
      slot_r      <= '0;
      dts_r       <= '0;
      pcr_seen_r  <= 1'b0;
      last_pcr_r  <= '0;
      pos_r       <= '0;
      phase_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      open_r      <= open_nxt;
      flags_r     <= flags_nxt;
      pid_r       <= pid_nxt;
      slot_r      <= slot_nxt;
      dts_r       <= dts_nxt;
      pcr_seen_r  <= pcr_seen_nxt;
      last_pcr_r  <= last_pcr_nxt;
      pos_r       <= pos_nxt;
      phase_r     <= phase_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        case (cfg_addr)
          CFG_PCR_PID:      pcr_pid_r <= cfg_data[12:0];
          CFG_PCR_INTERVAL: pcr_ms_r  <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      byte_r    <= in_tdata[24:17];
      first_r   <= in_tdata[25];
      last_r    <= in_tlast;
      key_r     <= in_tdata[26];
      dts_in_r  <= in_tdata[59:27];
      pid_in_r  <= in_tdata[16:4];
      slot_in_r <= slot_in;
    end
    af_total_r <= af_total_nxt;
    cc_r       <= cc_nxt;
    bld_r      <= bld_nxt;
    out_word_r <= out_word_nxt;
    out_cnt_r  <= out_cnt_nxt;
    out_end_r  <= out_end_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'h0, out_cnt_r, out_word_r};
  assign out_tlast  = out_end_r;

  a_fill_room: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= 8'(ROOM))
    else $error("payload fill beyond room");

  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= 8'(LAST_POS))
    else $error("packet byte position beyond packet");

  a_end_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> out_tdata[67:64] == 4'd4)
    else $error("packet end beat without four bytes");

  a_no_accept_emit: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_EMIT |-> !in_tready)
    else $error("input accepted during packet emission");

endmodule

[tb/sv/tps_checker.sv]
// Checker for the transport stream PES packetizer: watches input, config and
// output beats, predicts the packet words and compares them. Depends on tps_pkg.
`timescale 1ns / 100ps

module tps_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [63:0] in_tdata,
  input  logic        in_tlast,
  input  logic        in_tuser,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [71:0] out_tdata,
  input  logic        out_tlast,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic        cfg_addr,
  input  logic [15:0] cfg_data,
  output int          fail_count,
  output int          words_pending
);
  import tps_pkg::*;

  typedef struct {
    logic [63:0] word;
    logic [3:0]  count;
    logic        pkt_end;
  } pkt_word_t;

  pkt_word_t   word_q[$];
  logic [3:0]  cc_tab[16];
  logic        disc_tab[16];
  logic [7:0]  pay_buf[ROOM];
  int          fill;
  logic        first_open;
  logic [2:0]  flags;
  logic [12:0] cur_pid;
  logic [3:0]  cur_slot;
  logic [32:0] cur_dts;
  logic        pcr_seen;
  logic [32:0] last_pcr;
  logic [12:0] pcr_pid;
  logic [15:0] pcr_ms;

  task automatic build_packet();
    logic [7:0] p[PKT_LEN];
    int pos, af_total, af_len;
    logic [2:0] fl;
    logic [32:0] b;
    pkt_word_t w;
    pos = 4;
    af_total = ROOM - fill;
    p[0] = SYNC_BYTE;
    p[1] = (first_open ? PUSI_BIT : 8'h00) | {3'b0, cur_pid[12:8]};
    p[2] = cur_pid[7:0];
    p[3] = (af_total == 0 ? AFC_PAY : (fill == 0 ? AFC_AF : AFC_BOTH))
           | {4'b0, cc_tab[cur_slot]};
    if (af_total > 0) begin
      af_len = af_total - 1;
      p[pos++] = af_len[7:0];
      if (af_len > 0) begin
        fl = first_open ? flags : 3'b0;
        p[pos++] = (fl[AF_DISC] ? DISC_FLAG : 8'h00) | (fl[AF_RA] ? RA_FLAG : 8'h00)
                   | (fl[AF_PCR] ? PCR_FLAG : 8'h00);
        if (fl[AF_PCR]) begin
          b = cur_dts;
          p[pos++] = b[32:25];
          p[pos++] = b[24:17];
          p[pos++] = b[16:9];
          p[pos++] = b[8:1];
          p[pos++] = {b[0], PCR_RSVD};
          p[pos++] = 8'h00;
        end
        while (pos < 5 + af_len && pos < PKT_LEN) p[pos++] = STUFF_BYTE;
      end
    end
    for (int i = 0; i < fill && pos < PKT_LEN; i++) p[pos++] = pay_buf[i];
    while (pos < PKT_LEN) p[pos++] = STUFF_BYTE;
    if (fill > 0) cc_tab[cur_slot] = cc_tab[cur_slot] + 4'd1;
    first_open = 1'b0;
    fill = 0;
    for (int k = 0; k < 24; k++) begin
      w.word = '0;
      w.count = (k == 23) ? 4'd4 : 4'd8;
      for (int i = 0; i < 8; i++)
        w.word = {w.word[55:0], (i < w.count) ? p[k*8+i] : 8'h00};
      w.pkt_end = (k == 23);
      word_q.push_back(w);
    end
  endtask

  task automatic take_byte(logic [63:0] d, logic last, logic func);
    logic [3:0]  slot;
    logic [12:0] pid;
    logic [32:0] dts;
    logic [2:0]  fl;
    logic [32:0] diff;
    int cap;
    slot = d[3:0];
    pid = d[16:4];
    dts = d[59:27];
    if (func) begin
      disc_tab[slot] = 1'b1;
      return;
    end
    if (d[25]) begin
      fl = '0;
      cur_pid = pid;
      cur_slot = slot;
      cur_dts = dts;
      if (disc_tab[slot]) fl[AF_DISC] = 1'b1;
      disc_tab[slot] = 1'b0;
      if (d[26]) fl[AF_RA] = 1'b1;
      if (pid == pcr_pid) begin
        diff = dts - last_pcr;
        if (d[26] || !pcr_seen || 64'(diff) * 300 >= 64'(pcr_ms) * 27000) begin
          fl[AF_PCR] = 1'b1;
          pcr_seen = 1'b1;
          last_pcr = dts;
        end
      end
      flags = fl;
      first_open = 1'b1;
      fill = 0;
    end
    cap = ROOM - ((first_open && flags != 0) ? (flags[AF_PCR] ? 8 : 2) : 0);
    if (fill < ROOM) pay_buf[fill++] = d[24:17];
    if (fill >= cap || last) build_packet();
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      word_q.delete();
      for (int i = 0; i < 16; i++) begin
        cc_tab[i] = 4'd0;
        disc_tab[i] = 1'b0;
      end
      fill = 0;
      first_open = 0;
      flags = 0;
      cur_pid = 0;
      cur_slot = 0;
      cur_dts = 0;
      pcr_seen = 0;
      last_pcr = 0;
      pcr_pid = 13'd8191;
      pcr_ms = 16'd40;
      fail_count = 0;
      words_pending = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_addr == CFG_PCR_PID) pcr_pid = cfg_data[12:0];
        else pcr_ms = cfg_data;
      end
      if (in_tvalid && in_tready) take_byte(in_tdata, in_tlast, in_tuser);
      if (out_tvalid && out_tready) begin
        if (word_q.size() == 0) begin
          $error("unexpected output beat %h", out_tdata);
          fail_count++;
        end else begin
          pkt_word_t e;
          e = word_q.pop_front();
          if (out_tdata[63:0] !== e.word) begin
            $error("out_word expected %h actual %h", e.word, out_tdata[63:0]);
            fail_count++;
          end
          if (out_tdata[67:64] !== e.count) begin
            $error("out_count expected %0d actual %0d", e.count, out_tdata[67:64]);
            fail_count++;
          end
          if (out_tlast !== e.pkt_end) begin
            $error("packet_end expected %b actual %b", e.pkt_end, out_tlast);
            fail_count++;
          end
        end
      end
      words_pending = word_q.size();
    end
  end
endmodule

[tb/sv/testbench.sv]
// Top of the packetizer testbench: clock, reset, stimulus and verdict.
// Depends on tps_pkg, ts_pes_packetizer_core and tps_checker.
`timescale 1ns / 100ps

module testbench;
  import tps_pkg::*;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid, in_tready, in_tlast, in_tuser;
  logic [63:0] in_tdata;
  logic        out_tvalid, out_tready, out_tlast;
  logic [71:0] out_tdata;
  logic        cfg_valid, cfg_ready, cfg_addr;
  logic [15:0] cfg_data;
  int          fail_count, words_pending;
  bit          calm;

  ts_pes_packetizer_core i_dut (.*);
  tps_checker i_chk (.*);

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  initial begin
    #400ms;
    $display("CHECKS FAILED");
    $finish;
  end

  // Output stall: about 12 in 100 chances, none while calm is set.
  always @(posedge clk) out_tready <= calm || ($urandom_range(99) >= 12);

  task automatic send_beat(logic [12:0] pid, logic [3:0] slot, logic [7:0] b,
                           logic first, logic last, logic key, logic [32:0] dts,
                           logic func);
    while (!calm && $urandom_range(99) < 12) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {4'b0, dts, key, first, b, pid, slot};
    in_tlast <= last;
    in_tuser <= func;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic send_unit(logic [12:0] pid, logic [3:0] slot, int len, logic key,
                           logic [32:0] dts);
    for (int i = 0; i < len; i++)
      send_beat(pid, slot, 8'($urandom), i == 0, i == len - 1, key, dts, 1'b0);
  endtask

  task automatic write_reg(logic a, logic [15:0] d);
    in_tvalid <= 1'b0;
    while (words_pending != 0) @(posedge clk);
    repeat (800) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_addr <= a;
    cfg_data <= d;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    int n;
    logic [32:0] dts;
    logic [12:0] pid;
    rst_n = 0;
    in_tvalid = 0;
    in_tdata = '0;
    in_tlast = 0;
    in_tuser = 0;
    cfg_valid = 0;
    cfg_addr = CFG_PCR_PID;
    cfg_data = '0;
    calm = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    // Directed: orphan byte, extremes, marks, PCR cases, aborted unit.
    send_beat(13'h1FFF, 4'hF, 8'hFF, 0, 1, 1, '1, 0);
    write_reg(CFG_PCR_PID, 16'd0);
    send_beat(0, 0, 0, 0, 0, 0, 0, 1);
    send_beat(0, 5, 0, 0, 0, 0, 0, 1);
    send_unit(0, 0, 1, 0, 33'h0);
    send_unit(0, 0, 2, 0, 33'h1FFFFFFFF);
    send_unit(0, 5, 3, 1, 33'h155555555);
    send_unit(13'h1FFF, 15, 183, 1, 33'h0AAAAAAAA);
    send_beat(7, 3, 8'h12, 1, 0, 0, 5, 0);
    send_beat(7, 3, 8'h34, 0, 0, 0, 5, 0);
    send_unit(7, 3, 2, 0, 9);
    write_reg(CFG_PCR_INTERVAL, 16'd0);
    send_unit(0, 1, 2, 0, 33'd10);
    write_reg(CFG_PCR_INTERVAL, 16'hFFFF);
    send_unit(0, 1, 2, 0, 33'd20);
    send_unit(0, 1, 2, 1, 33'd30);
    // Random units across a few register settings.
    n = 0;
    for (int ph = 0; ph < 4; ph++) begin
      write_reg(CFG_PCR_PID, 16'($urandom_range(3)));
      write_reg(CFG_PCR_INTERVAL, ph == 3 ? 16'd1 : 16'($urandom_range(40)));
      dts = 33'($urandom);
      for (int u = 0; u < 25; u++) begin
        int len, r;
        calm = (ph == 2);
        r = $urandom_range(99);
        pid = ($urandom_range(3) == 0) ? 13'($urandom) : 13'($urandom_range(3));
        dts = dts + 33'($urandom_range(5000));
        len = (r < 4) ? $urandom_range(184, 260) : $urandom_range(1, 12);
        if (r < 8) send_beat(0, 4'($urandom), 0, 0, 0, 0, 0, 1);
        else if (r < 14) send_beat(pid, 4'($urandom), 8'($urandom), 0,
                                   1'($urandom_range(1)), 0, 0, 0);
        else if (r < 18) send_beat(pid, 4'($urandom), 8'($urandom), 1, 0, 1, dts, 0);
        send_unit(pid, 4'($urandom), len, 1'($urandom_range(1)), dts);
        n += len;
        if (n > 250 * (ph + 1) / 4 && u > 3) break;
      end
    end
    calm = 0;
    in_tvalid <= 1'b0;
    fork
      begin
        while (words_pending != 0) @(posedge clk);
        repeat (800) @(posedge clk);
        if (fail_count == 0)
          $display("ALL CHECKS PASSED");
        else
          $display("CHECKS FAILED");
      end
    join
    $finish;
  end
endmodule
